// ===== hw/rtl/spcs_pkg.sv =====
// ----------------------------------------------------------------------------
// spcs_pkg - square pulse channel shared definitions
// Event codes, register indexes, field widths and the duty pattern table.
// ----------------------------------------------------------------------------
package spcs_pkg;

   // Field widths
   localparam int OP_W       = 3;
   localparam int LEN_IN_W   = 7;
   localparam int PERIOD_W   = 11;
   localparam int PCOUNT_W   = 12;
   localparam int VOL_W      = 4;
   localparam int PACE_W     = 3;
   localparam int SCOUNT_W   = 4;
   localparam int DUTY_W     = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;

   // Defaults for the top-level parameters
   localparam int HAS_SWEEP_DEF  = 1;
   localparam int LENGTH_MAX_DEF = 64;

   // Fixed constants
   localparam logic [PCOUNT_W-1:0] PERIOD_LIMIT      = 12'd2048;
   localparam logic [VOL_W-1:0]    VOLUME_TOP        = 4'd15;
   localparam logic [SCOUNT_W-1:0] SWEEP_IDLE_RELOAD = 4'd8;
   localparam logic [DUTY_W-1:0]   DUTY_MSB          = 3'd7;

   // Event codes
   localparam logic [OP_W-1:0] OP_TRIGGER     = 3'd0;
   localparam logic [OP_W-1:0] OP_TIMER_STEP  = 3'd1;
   localparam logic [OP_W-1:0] OP_LENGTH_CLK  = 3'd2;
   localparam logic [OP_W-1:0] OP_ENV_CLK     = 3'd3;
   localparam logic [OP_W-1:0] OP_SWEEP_CLK   = 3'd4;
   localparam logic [OP_W-1:0] OP_LENGTH_LOAD = 3'd5;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_PERIOD       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DUTY_SELECT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INIT_VOLUME  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ENV_PACE     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SWEEP_PACE   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SWEEP_SHIFT  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_MODE_FLAGS   = 3'd6;

   // Mode flag bit positions
   localparam int MODE_ENV_UP     = 0;
   localparam int MODE_SWEEP_DOWN = 1;
   localparam int MODE_LEN_EN     = 2;
   localparam int MODE_DAC_ON     = 3;

   // Duty waveform, bit 7 is played first
   function automatic logic [7:0] duty_pattern(input logic [1:0] sel);
      logic [7:0] pat;
      case (sel)
         2'd0:    pat = 8'h01;
         2'd1:    pat = 8'h03;
         2'd2:    pat = 8'h0F;
         2'd3:    pat = 8'hFC;
         default: pat = 8'h01;
      endcase
      return pat;
   endfunction

   // Sweep target: shadow +/- (shadow >> shift); bit 11 flags overflow
   function automatic logic [PCOUNT_W-1:0] sweep_calc(input logic [PERIOD_W-1:0] shadow,
                                                      input logic [PACE_W-1:0]   shift,
                                                      input logic                down);
      logic [PCOUNT_W-1:0] base;
      logic [PCOUNT_W-1:0] off;
      base = {1'b0, shadow};
      off  = base >> shift;
      return down ? (base - off) : (base + off);
   endfunction

endpackage

// ===== hw/rtl/square_pulse_channel_with_sweep_top.sv =====
// Path: a transfer accepted on the request side passes through the input register,
//   then the result register, before it shows up on the response side.
// Throughput: one event per cycle while rsp_stall is low; the channel state updates
//   in one pass between the input register and the result register.
// Reset: synchronous, active high; clears all channel state, the config
//   registers and both pipeline valids. No clearing pass is needed.
// ----------------------------------------------------------------------------
// square_pulse_channel_with_sweep_top - pulse sound channel with sweep
// Handles trigger, timer, length, envelope, sweep and length-load events and
// returns one sample/status transfer per event.
// ----------------------------------------------------------------------------
module square_pulse_channel_with_sweep_top #(
   parameter int HAS_SWEEP  = spcs_pkg::HAS_SWEEP_DEF,
   parameter int LENGTH_MAX = spcs_pkg::LENGTH_MAX_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration write port
   input  logic                              csr_wr_en,
   input  logic [spcs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [spcs_pkg::CSR_DATA_W-1:0]   csr_wdata,
   // event input
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [spcs_pkg::OP_W-1:0]         req_op,
   input  logic [spcs_pkg::LEN_IN_W-1:0]     req_length_value,
   // result output
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [spcs_pkg::VOL_W-1:0]        rsp_sample_level,
   output logic                              rsp_channel_on,
   output logic [spcs_pkg::PERIOD_W-1:0]     rsp_current_period
);

   // length counter holds up to LENGTH_MAX and any 7-bit load value
   localparam int LEN_BITS = $clog2(LENGTH_MAX + 1);
   localparam int LEN_W    = (LEN_BITS > spcs_pkg::LEN_IN_W) ? LEN_BITS : spcs_pkg::LEN_IN_W;

   // ---------------- configuration registers ----------------
   logic [1:0]                     duty_select_ff;
   logic [spcs_pkg::VOL_W-1:0]     initial_volume_ff;
   logic [spcs_pkg::PACE_W-1:0]    envelope_pace_ff;
   logic [spcs_pkg::PACE_W-1:0]    sweep_pace_ff;
   logic [spcs_pkg::PACE_W-1:0]    sweep_shift_ff;
   logic [3:0]                     mode_flags_ff;

   // ---------------- channel state ----------------
   logic                           channel_enabled_ff, channel_enabled_in;
   logic [LEN_W-1:0]               length_count_ff, length_count_in;
   logic [spcs_pkg::PCOUNT_W-1:0]  period_count_ff, period_count_in;
   logic [spcs_pkg::DUTY_W-1:0]    duty_step_ff, duty_step_in;
   logic [spcs_pkg::PACE_W-1:0]    envelope_count_ff, envelope_count_in;
   logic [spcs_pkg::VOL_W-1:0]     volume_now_ff, volume_now_in;
   logic [spcs_pkg::PERIOD_W-1:0]  working_period_ff, working_period_in;
   logic [spcs_pkg::PERIOD_W-1:0]  sweep_shadow_ff, sweep_shadow_in;
   logic [spcs_pkg::SCOUNT_W-1:0]  sweep_count_ff, sweep_count_in;
   logic                           sweep_active_ff, sweep_active_in;

   // ---------------- pipeline registers ----------------
   logic                           s1_valid_ff;
   logic [spcs_pkg::OP_W-1:0]      s1_op_ff;
   logic [spcs_pkg::LEN_IN_W-1:0]  s1_length_value_ff;
   logic                           rsp_valid_ff;
   logic [spcs_pkg::VOL_W-1:0]     rsp_level_ff, rsp_level_in;
   logic                           rsp_on_ff;
   logic [spcs_pkg::PERIOD_W-1:0]  rsp_period_ff;

   // ---------------- working signals ----------------
   logic                           out_free;
   logic                           s1_adv;
   logic                           dac_on;
   logic                           has_sweep;
   logic [spcs_pkg::PCOUNT_W-1:0]  reload_val;
   logic [spcs_pkg::PERIOD_W-1:0]  sweep_src;
   logic [spcs_pkg::PCOUNT_W-1:0]  sweep_next1;
   logic [spcs_pkg::PCOUNT_W-1:0]  sweep_next2;
   logic [spcs_pkg::SCOUNT_W-1:0]  sweep_reload;
   logic [spcs_pkg::SCOUNT_W-1:0]  sweep_dec;
   logic [spcs_pkg::PACE_W-1:0]    env_dec;
   logic [LEN_W-1:0]               length_dec;
   logic [7:0]                     duty_bits;

   // Handshake: output register frees when empty or being taken
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_adv    = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;

   assign dac_on     = mode_flags_ff[spcs_pkg::MODE_DAC_ON];
   assign has_sweep  = (HAS_SWEEP != 0);
   assign reload_val = spcs_pkg::PERIOD_LIMIT - {1'b0, working_period_ff};

   // Sweep target checks: trigger checks the working period, a sweep clock
   // checks the shadow, then the freshly written period once more
   assign sweep_src   = (s1_op_ff == spcs_pkg::OP_TRIGGER) ? working_period_ff
                                                           : sweep_shadow_ff;
   assign sweep_next1 = spcs_pkg::sweep_calc(sweep_src, sweep_shift_ff,
                                             mode_flags_ff[spcs_pkg::MODE_SWEEP_DOWN]);
   assign sweep_next2 = spcs_pkg::sweep_calc(sweep_next1[spcs_pkg::PERIOD_W-1:0],
                                             sweep_shift_ff,
                                             mode_flags_ff[spcs_pkg::MODE_SWEEP_DOWN]);
   assign sweep_reload = (sweep_pace_ff != '0) ? spcs_pkg::SCOUNT_W'(sweep_pace_ff)
                                               : spcs_pkg::SWEEP_IDLE_RELOAD;
   assign sweep_dec  = (sweep_count_ff != '0) ? (sweep_count_ff - 1'b1) : sweep_count_ff;
   assign env_dec    = (envelope_count_ff != '0) ? (envelope_count_ff - 1'b1)
                                                 : envelope_count_ff;
   assign length_dec = length_count_ff - 1'b1;
   assign duty_bits  = spcs_pkg::duty_pattern(duty_select_ff);

   // Event processing: next state and result level
   always_comb begin
      channel_enabled_in = channel_enabled_ff;
      length_count_in    = length_count_ff;
      period_count_in    = period_count_ff;
      duty_step_in       = duty_step_ff;
      envelope_count_in  = envelope_count_ff;
      volume_now_in      = volume_now_ff;
      working_period_in  = working_period_ff;
      sweep_shadow_in    = sweep_shadow_ff;
      sweep_count_in     = sweep_count_ff;
      sweep_active_in    = sweep_active_ff;
      rsp_level_in       = '0;

      if (s1_adv) begin
         case (s1_op_ff)
            spcs_pkg::OP_TRIGGER: begin
               channel_enabled_in = dac_on;
               if (length_count_ff == '0) begin
                  length_count_in = LEN_W'(LENGTH_MAX);
               end
               period_count_in   = reload_val;
               envelope_count_in = envelope_pace_ff;
               volume_now_in     = initial_volume_ff;
               if (has_sweep) begin
                  sweep_shadow_in = working_period_ff;
                  sweep_count_in  = sweep_reload;
                  sweep_active_in = (sweep_pace_ff != '0) || (sweep_shift_ff != '0);
                  if ((sweep_shift_ff != '0) && sweep_next1[spcs_pkg::PERIOD_W]) begin
                     channel_enabled_in = 1'b0;
                  end
               end
            end
            spcs_pkg::OP_TIMER_STEP: begin
               if (channel_enabled_ff && dac_on) begin
                  if (period_count_ff <= spcs_pkg::PCOUNT_W'(1)) begin
                     period_count_in = reload_val;
                     duty_step_in    = duty_step_ff + 1'b1;
                  end else begin
                     period_count_in = period_count_ff - 1'b1;
                  end
                  if (duty_bits[spcs_pkg::DUTY_MSB - duty_step_in]) begin
                     rsp_level_in = volume_now_ff;
                  end
               end
            end
            spcs_pkg::OP_LENGTH_CLK: begin
               if (mode_flags_ff[spcs_pkg::MODE_LEN_EN] && (length_count_ff != '0)) begin
                  length_count_in = length_dec;
                  if (length_dec == '0) begin
                     channel_enabled_in = 1'b0;
                  end
               end
            end
            spcs_pkg::OP_ENV_CLK: begin
               if (envelope_pace_ff != '0) begin
                  envelope_count_in = env_dec;
                  if (env_dec == '0) begin
                     envelope_count_in = envelope_pace_ff;
                     if (mode_flags_ff[spcs_pkg::MODE_ENV_UP]) begin
                        if (volume_now_ff < spcs_pkg::VOLUME_TOP) begin
                           volume_now_in = volume_now_ff + 1'b1;
                        end
                     end else if (volume_now_ff != '0) begin
                        volume_now_in = volume_now_ff - 1'b1;
                     end
                  end
               end
            end
            spcs_pkg::OP_SWEEP_CLK: begin
               if (has_sweep) begin
                  sweep_count_in = sweep_dec;
                  if (sweep_dec == '0) begin
                     sweep_count_in = sweep_reload;
                     if (sweep_active_ff && (sweep_pace_ff != '0)) begin
                        if (sweep_next1[spcs_pkg::PERIOD_W]) begin
                           channel_enabled_in = 1'b0;
                        end else if (sweep_shift_ff != '0) begin
                           working_period_in = sweep_next1[spcs_pkg::PERIOD_W-1:0];
                           sweep_shadow_in   = sweep_next1[spcs_pkg::PERIOD_W-1:0];
                           if (sweep_next2[spcs_pkg::PERIOD_W]) begin
                              channel_enabled_in = 1'b0;
                           end
                        end
                     end
                  end
               end
            end
            spcs_pkg::OP_LENGTH_LOAD: begin
               length_count_in = LEN_W'(s1_length_value_ff);
            end
            default: begin
            end
         endcase
      end

      // period register write copies straight into the working period
      if (csr_wr_en && (csr_index == spcs_pkg::REG_PERIOD)) begin
         working_period_in = csr_wdata;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         duty_select_ff    <= '0;
         initial_volume_ff <= '0;
         envelope_pace_ff  <= '0;
         sweep_pace_ff     <= '0;
         sweep_shift_ff    <= '0;
         mode_flags_ff     <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            spcs_pkg::REG_DUTY_SELECT: duty_select_ff    <= csr_wdata[1:0];
            spcs_pkg::REG_INIT_VOLUME: initial_volume_ff <= csr_wdata[spcs_pkg::VOL_W-1:0];
            spcs_pkg::REG_ENV_PACE:    envelope_pace_ff  <= csr_wdata[spcs_pkg::PACE_W-1:0];
            spcs_pkg::REG_SWEEP_PACE:  sweep_pace_ff     <= csr_wdata[spcs_pkg::PACE_W-1:0];
            spcs_pkg::REG_SWEEP_SHIFT: sweep_shift_ff    <= csr_wdata[spcs_pkg::PACE_W-1:0];
            spcs_pkg::REG_MODE_FLAGS:  mode_flags_ff     <= csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   // Channel state
   always_ff @(posedge clock) begin
      if (reset) begin
         channel_enabled_ff <= 1'b0;
         length_count_ff    <= '0;
         period_count_ff    <= '0;
         duty_step_ff       <= '0;
         envelope_count_ff  <= '0;
         volume_now_ff      <= '0;
         working_period_ff  <= '0;
         sweep_shadow_ff    <= '0;
         sweep_count_ff     <= '0;
         sweep_active_ff    <= 1'b0;
      end else begin
         channel_enabled_ff <= channel_enabled_in;
         length_count_ff    <= length_count_in;
         period_count_ff    <= period_count_in;
         duty_step_ff       <= duty_step_in;
         envelope_count_ff  <= envelope_count_in;
         volume_now_ff      <= volume_now_in;
         working_period_ff  <= working_period_in;
         sweep_shadow_ff    <= sweep_shadow_in;
         sweep_count_ff     <= sweep_count_in;
         sweep_active_ff    <= sweep_active_in;
      end
   end

   // Input register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   // Input register payload
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_op_ff           <= req_op;
         s1_length_value_ff <= req_length_value;
      end
   end

   // Result register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   // Result register payload
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_level_ff  <= rsp_level_in;
         rsp_on_ff     <= channel_enabled_in;
         rsp_period_ff <= working_period_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sample_level   = rsp_level_ff;
   assign rsp_channel_on     = rsp_on_ff;
   assign rsp_current_period = rsp_period_ff;

   // ---------------- assertions ----------------
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("request stalled with empty input register");

   a_advance_gives_result: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_valid_ff)
      else $error("advanced event produced no result");

   a_level_needs_on: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_level_ff != '0)) |-> rsp_on_ff)
      else $error("nonzero sample from a disabled channel");

   a_period_count_range: assert property (@(posedge clock) disable iff (reset)
      period_count_ff <= spcs_pkg::PERIOD_LIMIT)
      else $error("period countdown above limit");

endmodule
